@@ sv/key_matrix_scan_report_builder_defines.svh @@
// assertion helpers for the key matrix report builder
`ifndef KEY_MATRIX_SCAN_REPORT_BUILDER_DEFINES_SVH
`define KEY_MATRIX_SCAN_REPORT_BUILDER_DEFINES_SVH

// plain invariant, checked on every edge outside reset
`define KMSRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form, antecedent and consequent given separately
`define KMSRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ sv/kmsrb_pkg.sv @@
package kmsrb_pkg;

  localparam int MaxRowsDef    = 16;
  localparam int MaxColumnsDef = 16;
  localparam int KeySlotsDef   = 6;

  // fixed by the field widths of a request and of a report
  localparam int CfgW     = 5;
  localparam int ColCntW  = 5;
  localparam int PosW     = 8;
  localparam int OutSlots = 6;
  localparam logic [CfgW-1:0] CfgResetVal = 5'd16;

  localparam logic CmdLayout = 1'b0;
  localparam logic CmdScan   = 1'b1;

  localparam logic [7:0] ModCodeFirst = 8'hE0;
  localparam logic [7:0] ModCodeLast  = 8'hE7;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSetup,
    StLayout,
    StScan,
    StFinish
  } state_e;

  typedef struct packed {
    logic        command;
    logic [3:0]  row_index;
    logic [3:0]  column_index;
    logic [7:0]  keycode_value;
    logic [15:0] column_levels;
    logic        first_row;
    logic        last_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] report_modifiers;
    logic [7:0] slot_zero;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
    logic [7:0] slot_five;
    logic [2:0] key_count;
    logic       report_empty;
  } out_item_t;

endpackage

@@ sv/key_matrix_scan_report_builder.sv @@
// Builds a six-key boot keyboard report from key matrix row samples. After reset the
// layout table is cleared by a pass that writes one entry per cycle over all
// MAX_ROWS*MAX_COLUMNS entries, during which in_stall_o stays high; column_count writes
// are taken at any time. A layout request passes through the setup and layout states. A
// row request passes through setup, scan and finish, ending the scan early once all key
// slots are full: the columns are walked one per cycle through the single read port of
// the layout table, with the slot/modifier update for each column made in the cycle
// after its table lookup, overlapping the next lookup. A report leaves through an output
// register, so the next request is taken while it waits; a second report waits for that
// register to drain before its request completes.
`include "key_matrix_scan_report_builder_defines.svh"

module key_matrix_scan_report_builder
  import kmsrb_pkg::*;
#(
  parameter int MAX_ROWS    = MaxRowsDef,
  parameter int MAX_COLUMNS = MaxColumnsDef,
  parameter int KEY_SLOTS   = KeySlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o
);

  localparam int MapDepth = MAX_ROWS * MAX_COLUMNS;
  localparam int AddrW    = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int DepthW   = $clog2(MapDepth + 1);
  localparam int CmpW     = (DepthW > PosW) ? DepthW : PosW;
  localparam int CntW     = $clog2(KEY_SLOTS + 1);
  localparam int ColLimit = (MAX_COLUMNS < 16) ? MAX_COLUMNS : 16;

  state_e state_q, state_d;

  logic [CfgW-1:0]    cfg_q;
  in_item_t           item_q, item_d;
  logic [PosW-1:0]    base_q, base_d;
  logic [ColCntW-1:0] col_q, col_d;
  logic               pend_q, pend_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [7:0]         mod_q, mod_d;
  logic [7:0]         slot_q [KEY_SLOTS];
  logic [7:0]         slot_d [KEY_SLOTS];
  logic [CntW-1:0]    filled_q, filled_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  logic [7:0]       mem [MapDepth];
  logic [7:0]       rd_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  logic [ColCntW-1:0] ncols;
  logic [PosW-1:0]    pos;
  logic [CmpW-1:0]    pos_ext;
  logic               pos_ok;
  logic               full;
  logic [7:0]         slot_out [OutSlots];

  assign ncols   = (cfg_q > ColCntW'(ColLimit)) ? ColCntW'(ColLimit) : cfg_q;
  // shared address adder: row base plus column, for layout writes and the walk
  assign pos     = base_q + ((state_q == StLayout) ? PosW'(item_q.column_index)
                                                   : PosW'(col_q));
  assign pos_ext = CmpW'(pos);
  assign pos_ok  = pos_ext < CmpW'(MapDepth);
  assign full    = filled_q == CntW'(KEY_SLOTS);

  for (genvar g = 0; g < OutSlots; g++) begin : g_slot_out
    if (g < KEY_SLOTS) begin : g_used
      assign slot_out[g] = slot_q[g];
    end else begin : g_unused
      assign slot_out[g] = 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    base_d      = base_q;
    col_d       = col_q;
    pend_d      = 1'b0;
    clr_d       = clr_q;
    mod_d       = mod_q;
    slot_d      = slot_q;
    filled_d    = filled_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_ext[AddrW-1:0];
    mem_wdata   = item_q.keycode_value;
    mem_raddr   = pos_ext[AddrW-1:0];
    in_stall_o  = 1'b1;

    // lookup result of the column issued last cycle
    if (pend_q && !full && rd_q != 8'h00) begin
      if (rd_q >= ModCodeFirst && rd_q <= ModCodeLast) begin
        mod_d = mod_q | (8'h01 << rd_q[2:0]);
      end else begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (filled_q == CntW'(i)) begin
            slot_d[i] = rd_q;
          end
        end
        filled_d = filled_q + CntW'(1);
      end
    end

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'h00;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MapDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = StSetup;
        end
      end
      StSetup: begin
        base_d = PosW'(item_q.row_index) * PosW'(ncols);
        col_d  = '0;
        if (item_q.command == CmdLayout) begin
          state_d = StLayout;
        end else begin
          if (item_q.first_row) begin
            mod_d    = '0;
            filled_d = '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
              slot_d[i] = 8'h00;
            end
          end
          state_d = StScan;
        end
      end
      StLayout: begin
        mem_we  = (ColCntW'(item_q.column_index) < ncols) && pos_ok;
        state_d = StIdle;
      end
      StScan: begin
        if (full || filled_d == CntW'(KEY_SLOTS)) begin
          state_d = StFinish;
        end else if (col_q < ncols) begin
          pend_d = !item_q.column_levels[col_q[3:0]] && pos_ok;
          col_d  = col_q + ColCntW'(1);
        end else if (!pend_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!item_q.last_row) begin
          state_d = StIdle;
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d                 = 1'b1;
          out_item_d.report_modifiers = mod_q;
          out_item_d.slot_zero        = slot_out[0];
          out_item_d.slot_one         = slot_out[1];
          out_item_d.slot_two         = slot_out[2];
          out_item_d.slot_three       = slot_out[3];
          out_item_d.slot_four        = slot_out[4];
          out_item_d.slot_five        = slot_out[5];
          out_item_d.key_count        = (int'(filled_q) > 7) ? 3'd7 : 3'(filled_q);
          out_item_d.report_empty     = (mod_q == 8'h00) && (filled_q == '0);
          state_d                     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cfg_q       <= CfgResetVal;
      clr_q       <= '0;
      col_q       <= '0;
      pend_q      <= 1'b0;
      mod_q       <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_q[i] <= 8'h00;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      col_q       <= col_d;
      pend_q      <= pend_d;
      mod_q       <= mod_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
      slot_q      <= slot_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    base_q     <= base_d;
    out_item_q <= out_item_d;
  end

  // layout table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `KMSRB_ASSERT(a_filled_bound, int'(filled_q) <= KEY_SLOTS, "slot count past capacity")
  `KMSRB_ASSERT_IMP(a_clear_stalls, state_q == StClear, in_stall_o, "request taken during clear")
  `KMSRB_ASSERT_IMP(a_pend_in_scan, pend_q, state_q == StScan, "lookup pending outside scan")
  `KMSRB_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(state_q == StFinish),
                    "report raised outside finish")

endmodule
